// ===== rtl/core/awt_pkg.sv =====
// awt_pkg: shared widths, codes and types of the ack window tracker
package awt_pkg;

  localparam int FILE_W   = 32;
  localparam int OFFSET_W = 64;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 9;

  // opcodes of an input transfer
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  // one log position as held in the window store
  typedef struct packed {
    logic [FILE_W-1:0]   file;
    logic [OFFSET_W-1:0] offset;
  } log_pos_t;

endpackage

// ===== rtl/core/awt_req_if.sv =====
// awt_req_if: request channel carrying push and ack items
interface awt_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [awt_pkg::FILE_W-1:0]    file_number;
  logic [awt_pkg::OFFSET_W-1:0]  byte_offset;
  logic [awt_pkg::FILE_W-1:0]    end_file_number;
  logic [awt_pkg::OFFSET_W-1:0]  end_byte_offset;

  modport source (
    output valid, opcode, file_number, byte_offset, end_file_number, end_byte_offset,
    input  ready
  );
  modport sink (
    input  valid, opcode, file_number, byte_offset, end_file_number, end_byte_offset,
    output ready
  );
endinterface

// ===== rtl/core/awt_rsp_if.sv =====
// awt_rsp_if: result channel with status, acknowledged position and free slots
interface awt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [awt_pkg::STATUS_W-1:0]  status;
  logic [awt_pkg::FILE_W-1:0]    acked_file_number;
  logic [awt_pkg::OFFSET_W-1:0]  acked_byte_offset;
  logic [awt_pkg::FREE_W-1:0]    free_slots;

  modport source (
    output valid, status, acked_file_number, acked_byte_offset, free_slots,
    input  ready
  );
  modport sink (
    input  valid, status, acked_file_number, acked_byte_offset, free_slots,
    output ready
  );
endinterface

// ===== rtl/core/ack_window_tracker.sv =====
// ack_window_tracker: window of in-flight log positions with range acknowledge
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    opcode, file_number, byte_offset,
//                                end_file_number, end_byte_offset
//   rsp      out  valid/ready    status, acked_file_number, acked_byte_offset,
//                                free_slots
//
// A push goes from its transfer through the done state to the output register.
// A found ack scans entries up to its end, marks one acked bit per entry from
// start to end, then retires acked head entries with a read and a check each;
// all steps share the single read port of the position store and acked-bit store.
// An ack whose end is missing scans the whole window; one whose start is missing
// stops at its end entry; both report not found. req.ready is high only while the
// sequencer is idle, from the cycle after a result is registered; a result waits
// in the output register and the next request may be taken meanwhile.
// Synchronous reset clears the window indexes and the acknowledged position;
// the stores need no clearing since every entry in the window was pushed.
module ack_window_tracker #(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  awt_req_if.sink    req,
  awt_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_DEPTH - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_MARK    = 3'd2;
  localparam logic [2:0] ST_RET_RD  = 3'd3;
  localparam logic [2:0] ST_RET_CHK = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + IDX_W'(1);
  endfunction

  logic [2:0]                    state;
  logic [IDX_W-1:0]              head;
  logic [IDX_W-1:0]              tail;
  logic [CNT_W-1:0]              count;
  awt_pkg::log_pos_t             last_acked;
  logic [awt_pkg::STATUS_W-1:0]  res_status;

  // ack keys
  awt_pkg::log_pos_t             key_start;
  awt_pkg::log_pos_t             key_end;

  // scan and mark bookkeeping
  logic [CNT_W-1:0]              issue_pos;
  logic [IDX_W-1:0]              issue_slot;
  logic                          cmp_valid;
  logic [CNT_W-1:0]              cmp_pos;
  logic [IDX_W-1:0]              cmp_slot;
  logic                          have_start;
  logic [CNT_W-1:0]              start_idx;
  logic [IDX_W-1:0]              start_slot;
  logic [CNT_W-1:0]              end_pos;
  logic [CNT_W-1:0]              mark_pos;
  logic [IDX_W-1:0]              mark_slot;

  // stores
  awt_pkg::log_pos_t             pos_mem [WINDOW_DEPTH];
  logic                          ack_mem [WINDOW_DEPTH];
  awt_pkg::log_pos_t             pos_q;
  logic                          ack_q;

  logic                          pos_we;
  awt_pkg::log_pos_t             pos_wdata;
  logic                          ack_we;
  logic [IDX_W-1:0]              ack_waddr;
  logic                          ack_wdata;
  logic [IDX_W-1:0]              rd_addr;

  logic                          req_xfer;
  logic                          issuing;
  logic                          start_hit;
  logic                          end_hit;
  logic [CNT_W-1:0]              free_cnt;

  assign req.ready = (state == ST_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign issuing   = (issue_pos < count);
  assign start_hit = cmp_valid && (pos_q == key_start);
  assign end_hit   = cmp_valid && (pos_q == key_end);
  assign free_cnt  = DEPTH_CNT - count;

  // store write and read port control
  always_comb begin
    pos_we    = 1'b0;
    pos_wdata = {req.file_number, req.byte_offset};
    ack_we    = 1'b0;
    ack_waddr = tail;
    ack_wdata = 1'b0;
    rd_addr   = head;
    case (state)
      ST_IDLE: begin
        if (req_xfer && req.opcode == awt_pkg::OP_PUSH && count < DEPTH_CNT) begin
          pos_we = 1'b1;
          ack_we = 1'b1;
        end
      end
      ST_SCAN: begin
        rd_addr = issue_slot;
      end
      ST_MARK: begin
        ack_we    = 1'b1;
        ack_waddr = mark_slot;
        ack_wdata = 1'b1;
      end
      ST_RET_CHK: begin
        if (ack_q) begin
          ack_we    = 1'b1;
          ack_waddr = head;
        end
      end
      default: begin
      end
    endcase
  end

  // position store and acked-bit store
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[tail] <= pos_wdata;
    end
    if (ack_we) begin
      ack_mem[ack_waddr] <= ack_wdata;
    end
    pos_q <= pos_mem[rd_addr];
    ack_q <= ack_mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      last_acked <= '0;
      cmp_valid  <= 1'b0;
      have_start <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_xfer) begin
            key_start <= {req.file_number, req.byte_offset};
            key_end   <= {req.end_file_number, req.end_byte_offset};
            if (req.opcode == awt_pkg::OP_PUSH) begin
              state <= ST_DONE;
              if (count < DEPTH_CNT) begin
                tail       <= slot_inc(tail);
                count      <= count + CNT_W'(1);
                res_status <= awt_pkg::STATUS_OK;
              end else begin
                res_status <= awt_pkg::STATUS_FULL;
              end
            end else begin
              state      <= ST_SCAN;
              issue_pos  <= '0;
              issue_slot <= head;
              cmp_valid  <= 1'b0;
              have_start <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          // compare the entry read last cycle
          if (start_hit) begin
            have_start <= 1'b1;
            start_idx  <= cmp_pos;
            start_slot <= cmp_slot;
          end
          if (end_hit) begin
            cmp_valid <= 1'b0;
            end_pos   <= cmp_pos;
            if (start_hit) begin
              mark_pos  <= cmp_pos;
              mark_slot <= cmp_slot;
              state     <= ST_MARK;
            end else if (have_start) begin
              mark_pos  <= start_idx;
              mark_slot <= start_slot;
              state     <= ST_MARK;
            end else begin
              res_status <= awt_pkg::STATUS_NOT_FOUND;
              state      <= ST_DONE;
            end
          end else if (issuing) begin
            // read the next entry
            cmp_valid  <= 1'b1;
            cmp_pos    <= issue_pos;
            cmp_slot   <= issue_slot;
            issue_pos  <= issue_pos + CNT_W'(1);
            issue_slot <= slot_inc(issue_slot);
          end else begin
            cmp_valid <= 1'b0;
            if (!cmp_valid) begin
              res_status <= awt_pkg::STATUS_NOT_FOUND;
              state      <= ST_DONE;
            end
          end
        end
        ST_MARK: begin
          // one acked bit per cycle from start to end
          if (mark_pos == end_pos) begin
            state <= ST_RET_RD;
          end else begin
            mark_pos  <= mark_pos + CNT_W'(1);
            mark_slot <= slot_inc(mark_slot);
          end
        end
        ST_RET_RD: begin
          res_status <= awt_pkg::STATUS_OK;
          state      <= (count == '0) ? ST_DONE : ST_RET_CHK;
        end
        ST_RET_CHK: begin
          // retire the head entry while it is acked
          if (ack_q) begin
            last_acked <= pos_q;
            head       <= slot_inc(head);
            count      <= count - CNT_W'(1);
            state      <= ST_RET_RD;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == ST_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status            <= res_status;
      rsp.acked_file_number <= last_acked.file;
      rsp.acked_byte_offset <= last_acked.offset;
      rsp.free_slots        <= awt_pkg::FREE_W'(free_cnt);
    end
  end

  // window never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("window count above depth");

  // a push into a window with room grows it by one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (req_xfer && req.opcode == awt_pkg::OP_PUSH && count < DEPTH_CNT)
      |=> count == $past(count) + CNT_W'(1))
    else $error("push did not grow window");

  // an idle empty window has its tail at its head
  a_tail_track: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && count == '0) |-> tail == head)
    else $error("empty window with tail away from head");

  // a full status is only reported with no free slot
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == awt_pkg::STATUS_FULL) |-> $past(count) == DEPTH_CNT
      || !$past(rsp.valid) || $past(rsp.valid && !rsp.ready))
    else $error("full status with room left");

endmodule
